[rtl/core/lcdn_pkg.sv]
`timescale 1ns / 1ps
// lcdn_pkg: shared types, codes, constants and timer helpers for the
// character lcd nibble interface. No dependencies.
package lcdn_pkg;

	// timer
	localparam int TIMER_BITS = 16;
	typedef logic [TIMER_BITS-1:0] timer_t;
	localparam logic [31:0] TIMER_MAX = 32'((64'd1 << TIMER_BITS) - 64'd1);

	// request codes on the cmd field
	typedef enum logic [2:0] {
		CMD_TICK    = 3'd0,
		CMD_COMMAND = 3'd1,
		CMD_DATA    = 3'd2,
		CMD_TEXT    = 3'd3,
		CMD_HEX     = 3'd4
	} lcdn_code_t;

	// configuration register indexes
	typedef enum logic [2:0] {
		REG_POWERUP_WAIT  = 3'd0,
		REG_INIT_FIRST    = 3'd1,
		REG_INIT_SECOND   = 3'd2,
		REG_INIT_STEP     = 3'd3,
		REG_COMMAND_PULSE = 3'd4,
		REG_DATA_PULSE    = 3'd5
	} lcdn_reg_t;

	localparam int CFG_IDX_BITS = 3;

	// bus engine phases
	typedef enum logic [3:0] {
		PH_PWR      = 4'd0,
		PH_INIT_HI  = 4'd1,
		PH_INIT_LO  = 4'd2,
		PH_CMD_HI   = 4'd3,
		PH_CMD_GAP  = 4'd4,
		PH_CMD_LO   = 4'd5,
		PH_CMD_WAIT = 4'd6,
		PH_DAT_HI   = 4'd7,
		PH_DAT_GAP  = 4'd8,
		PH_DAT_LO   = 4'd9,
		PH_DAT_END  = 4'd10,
		PH_IDLE     = 4'd11
	} lcdn_phase_t;

	// classified item kinds
	typedef enum logic [1:0] {
		OP_NOP  = 2'd0,
		OP_TICK = 2'd1,
		OP_REQ  = 2'd2
	} lcdn_op_t;

	typedef struct packed {
		lcdn_op_t   kind;
		logic       is_cmd;      // first byte goes out as a command
		logic [7:0] xfer_byte;   // first byte to send
		logic       pend_set;    // a second byte follows
		logic       pend_cmd;
		logic [7:0] pend_byte;
	} lcdn_item_t;

	typedef struct packed {
		logic [15:0] powerup_wait_us;
		logic [15:0] init_first_pulse_us;
		logic [15:0] init_second_pulse_us;
		logic [15:0] init_step_pulse_us;
		logic [15:0] command_pulse_us;
		logic [15:0] data_pulse_us;
	} lcdn_cfg_t;

	// fixed bytes
	localparam logic [7:0] BYTE_FUNCTION_SET = 8'h28;
	localparam logic [7:0] BYTE_DISPLAY_ON   = 8'h0C;
	localparam logic [7:0] BYTE_CLEAR        = 8'h01;
	localparam logic [7:0] BYTE_ENTRY_MODE   = 8'h06;
	localparam logic [7:0] BYTE_LINE_TWO     = 8'hC0;
	localparam logic [7:0] BYTE_HOME         = 8'h03;
	localparam logic [7:0] BYTE_NEWLINE      = 8'h0A;
	localparam logic [7:0] BYTE_INIT_8BIT    = 8'b0011_0000;
	localparam logic [7:0] BYTE_INIT_4BIT    = 8'b0010_0000;

	function automatic logic [7:0] setup_cmd(input logic [1:0] idx);
		logic [7:0] r;
		unique case (idx)
			2'd0: r = BYTE_FUNCTION_SET;
			2'd1: r = BYTE_DISPLAY_ON;
			2'd2: r = BYTE_CLEAR;
			default: r = BYTE_ENTRY_MODE;
		endcase
		return r;
	endfunction

	// zero acts as one, large values clamp to the timer range
	function automatic timer_t load_len(input logic [15:0] v);
		logic [31:0] n;
		n = {16'd0, v};
		if (n == 32'd0) n = 32'd1;
		if (n > TIMER_MAX) n = TIMER_MAX;
		return n[TIMER_BITS-1:0];
	endfunction

endpackage

[rtl/core/char_lcd_nibble_interface_unit.sv]
`timescale 1ns / 1ps
// char_lcd_nibble_interface_unit: top level of the character lcd 4-bit bus
// controller. Depends on lcdn_pkg, lcdn_front, lcdn_queue and lcdn_back.

// Each input transaction is a one-microsecond tick (cmd 0) or a request
// (1 command byte, 2 data byte, 3 text character, 4 hex byte); every input
// transaction yields exactly one result transaction showing the bus lines
// (bus_nibble, reg_select, enable), busy_res and rejected after that item.
// After reset the controller counts powerup_wait_us ticks, runs the 4-bit
// init nibbles and setup commands 0x28, 0x0C, 0x01, 0x06, and only then
// accepts requests; a request arriving while busy is dropped with rejected
// set. Throughput is one transaction per clock while out_ready holds high:
// the front classifies the item as it enters a two-entry queue, and the bus
// engine retires one queue entry per cycle into the result register, which
// stalls while a result waits on out_ready.
// Configuration writes are always accepted (cfg_ready is tied high) and
// should be made while the block is idle.
module char_lcd_nibble_interface_unit (
	input  logic        clk,
	input  logic        arst_n,
	// item channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  cmd,
	input  logic [7:0]  value,
	input  logic        last,
	// result channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic [3:0]  bus_nibble,
	output logic        reg_select,
	output logic        enable,
	output logic        busy_res,
	output logic        rejected,
	// configuration write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [lcdn_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  logic [15:0] cfg_data
);
	import lcdn_pkg::*;

	lcdn_item_t front_item;
	lcdn_item_t head_item;
	logic       q_full;
	logic       q_avail;
	logic       q_pop;
	logic       in_fire;
	lcdn_cfg_t  cfg_q;

	// config registers, written whenever the channel fires
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.powerup_wait_us      <= 16'd20000;
			cfg_q.init_first_pulse_us  <= 16'd5000;
			cfg_q.init_second_pulse_us <= 16'd200;
			cfg_q.init_step_pulse_us   <= 16'd2000;
			cfg_q.command_pulse_us     <= 16'd2000;
			cfg_q.data_pulse_us        <= 16'd40;
		end else if (cfg_valid && cfg_ready) begin
			// indexes past the register list are ignored
			unique case (cfg_index)
				REG_POWERUP_WAIT:  cfg_q.powerup_wait_us      <= cfg_data;
				REG_INIT_FIRST:    cfg_q.init_first_pulse_us  <= cfg_data;
				REG_INIT_SECOND:   cfg_q.init_second_pulse_us <= cfg_data;
				REG_INIT_STEP:     cfg_q.init_step_pulse_us   <= cfg_data;
				REG_COMMAND_PULSE: cfg_q.command_pulse_us     <= cfg_data;
				REG_DATA_PULSE:    cfg_q.data_pulse_us        <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// front: classify and expand the incoming item
	lcdn_front u_front (
		.cmd   (cmd),
		.value (value),
		.last  (last),
		.item  (front_item)
	);

	// accept while the queue has room, independent of the result side
	assign in_ready = !q_full;
	assign in_fire  = in_valid && in_ready;

	lcdn_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (in_fire),
		.push_item (front_item),
		.full      (q_full),
		.pop       (q_pop),
		.avail     (q_avail),
		.head      (head_item)
	);

	// back: phase machine and result register
	lcdn_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.avail      (q_avail),
		.head       (head_item),
		.pop        (q_pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.bus_nibble (bus_nibble),
		.reg_select (reg_select),
		.enable     (enable),
		.busy_res   (busy_res),
		.rejected   (rejected)
	);

endmodule

[rtl/core/lcdn_front.sv]
`timescale 1ns / 1ps
// lcdn_front: classifies an incoming item into tick, request or no-op and
// expands hex and final-text requests into byte pairs. Depends on lcdn_pkg.
module lcdn_front (
	input  logic [2:0]         cmd,
	input  logic [7:0]         value,
	input  logic               last,
	output lcdn_pkg::lcdn_item_t item
);
	import lcdn_pkg::*;

	function automatic logic [7:0] hex_digit(input logic [3:0] n);
		logic [7:0] r;
		if (n < 4'd10) r = 8'h30 | {4'd0, n};
		else r = 8'h37 + {4'd0, n};
		return r;
	endfunction

	always_comb begin
		item = '0;
		item.kind = OP_NOP;
		unique case (cmd)
			CMD_TICK: begin
				item.kind = OP_TICK;
			end
			CMD_COMMAND: begin
				item.kind = OP_REQ;
				item.is_cmd = 1'b1;
				item.xfer_byte = value;
			end
			CMD_DATA: begin
				item.kind = OP_REQ;
				item.xfer_byte = value;
			end
			CMD_TEXT: begin
				item.kind = OP_REQ;
				// newline moves the cursor to line two
				item.is_cmd = (value == BYTE_NEWLINE);
				item.xfer_byte = (value == BYTE_NEWLINE) ? BYTE_LINE_TWO : value;
				item.pend_set = last;
				item.pend_cmd = 1'b1;
				item.pend_byte = BYTE_HOME;
			end
			CMD_HEX: begin
				item.kind = OP_REQ;
				item.xfer_byte = hex_digit(value[7:4]);
				item.pend_set = 1'b1;
				item.pend_byte = hex_digit(value[3:0]);
			end
			default: begin
				item.kind = OP_NOP;
			end
		endcase
	end

endmodule

[rtl/core/lcdn_queue.sv]
`timescale 1ns / 1ps
// lcdn_queue: two-entry queue of classified items between the front and
// the bus engine. Depends on lcdn_pkg.
module lcdn_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  lcdn_pkg::lcdn_item_t push_item,
	output logic                full,
	input  logic                pop,
	output logic                avail,
	output lcdn_pkg::lcdn_item_t head
);
	import lcdn_pkg::*;

	lcdn_item_t entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full  = (count_q == 2'd2);
	assign avail = (count_q != 2'd0);
	assign head  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop)  rd_ptr_q <= ~rd_ptr_q;
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

[rtl/core/lcdn_back.sv]
`timescale 1ns / 1ps
// lcdn_back: bus engine with phase machine, up/down tick timer, pending byte
// and the result register. Depends on lcdn_pkg.
module lcdn_back (
	input  logic                clk,
	input  logic                arst_n,
	input  lcdn_pkg::lcdn_cfg_t  cfg,
	input  logic                avail,
	input  lcdn_pkg::lcdn_item_t head,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [3:0]          bus_nibble,
	output logic                reg_select,
	output logic                enable,
	output logic                busy_res,
	output logic                rejected
);
	import lcdn_pkg::*;

	lcdn_phase_t phase_q, phase_d;
	timer_t      timer_q, timer_d;
	logic [3:0]  step_q, step_d;
	logic [7:0]  byte_q, byte_d;
	logic        rs_q, rs_d;
	logic [7:0]  pend_byte_q, pend_byte_d;
	logic        pend_valid_q, pend_valid_d;
	logic        pend_cmd_q, pend_cmd_d;
	logic        rej_d;

	logic        out_valid_q;
	logic [3:0]  nib_q;
	logic        rs_out_q, en_q, busy_q, rej_q;
	logic [3:0]  nib_d;
	logic        en_d, busy_d;

	assign pop = avail && (!out_valid_q || out_ready);

	// next state
	always_comb begin
		timer_t      t_inc, t_dec;
		logic        go_cmd, go_dat, go_init;
		logic [7:0]  go_byte;
		logic [3:0]  s;

		phase_d      = phase_q;
		timer_d      = timer_q;
		step_d       = step_q;
		byte_d       = byte_q;
		rs_d         = rs_q;
		pend_byte_d  = pend_byte_q;
		pend_valid_d = pend_valid_q;
		pend_cmd_d   = pend_cmd_q;
		rej_d        = 1'b0;
		go_cmd       = 1'b0;
		go_dat       = 1'b0;
		go_init      = 1'b0;
		go_byte      = 8'd0;
		s            = step_q + 4'd1;
		t_inc        = timer_q + timer_t'(1);
		t_dec        = (timer_q != '0) ? timer_q - timer_t'(1) : timer_q;

		unique case (head.kind)
			OP_TICK: begin
				if (phase_q == PH_PWR) begin
					timer_d = t_inc;
					if (t_inc >= load_len(cfg.powerup_wait_us)) begin
						step_d  = 4'd0;
						go_init = 1'b1;
					end
				end else if (phase_q != PH_IDLE) begin
					timer_d = t_dec;
					if (t_dec == '0) begin
						unique case (phase_q)
							PH_INIT_HI: begin
								phase_d = PH_INIT_LO;
								timer_d = timer_t'(1);
							end
							PH_INIT_LO: begin
								if (s < 4'd4) begin
									step_d  = s;
									go_init = 1'b1;
								end else begin
									step_d  = 4'd4;
									go_cmd  = 1'b1;
									go_byte = setup_cmd(2'd0);
								end
							end
							PH_CMD_HI: begin
								phase_d = PH_CMD_GAP;
								timer_d = timer_t'(1);
							end
							PH_CMD_GAP: begin
								phase_d = PH_CMD_LO;
								timer_d = load_len(cfg.command_pulse_us);
							end
							PH_CMD_LO: begin
								phase_d = PH_CMD_WAIT;
								timer_d = load_len(cfg.command_pulse_us);
							end
							PH_DAT_HI: begin
								phase_d = PH_DAT_GAP;
								timer_d = timer_t'(1);
							end
							PH_DAT_GAP: begin
								phase_d = PH_DAT_LO;
								timer_d = load_len(cfg.data_pulse_us);
							end
							PH_DAT_LO: begin
								phase_d = PH_DAT_END;
								timer_d = timer_t'(1);
							end
							PH_CMD_WAIT, PH_DAT_END: begin
								// setup commands first, then a pending byte
								if (step_q >= 4'd4 && step_q < 4'd8) step_d = s;
								if (step_q >= 4'd4 && step_q < 4'd7) begin
									go_cmd  = 1'b1;
									go_byte = setup_cmd(2'(s - 4'd4));
								end else if (pend_valid_q) begin
									pend_valid_d = 1'b0;
									go_cmd       = pend_cmd_q;
									go_dat       = !pend_cmd_q;
									go_byte      = pend_byte_q;
								end else begin
									phase_d = PH_IDLE;
								end
							end
							default: begin
								phase_d = PH_IDLE;
							end
						endcase
					end
				end
			end
			OP_REQ: begin
				if (phase_q != PH_IDLE) begin
					rej_d = 1'b1;
				end else begin
					if (head.pend_set) begin
						pend_valid_d = 1'b1;
						pend_cmd_d   = head.pend_cmd;
						pend_byte_d  = head.pend_byte;
					end
					go_cmd  = head.is_cmd;
					go_dat  = !head.is_cmd;
					go_byte = head.xfer_byte;
				end
			end
			default: begin
			end
		endcase

		if (go_init) begin
			byte_d  = (step_d < 4'd3) ? BYTE_INIT_8BIT : BYTE_INIT_4BIT;
			rs_d    = 1'b0;
			phase_d = PH_INIT_HI;
			if (step_d == 4'd0)      timer_d = load_len(cfg.init_first_pulse_us);
			else if (step_d == 4'd1) timer_d = load_len(cfg.init_second_pulse_us);
			else                     timer_d = load_len(cfg.init_step_pulse_us);
		end
		if (go_cmd) begin
			byte_d  = go_byte;
			rs_d    = 1'b0;
			phase_d = PH_CMD_HI;
			timer_d = load_len(cfg.command_pulse_us);
		end
		if (go_dat) begin
			byte_d  = go_byte;
			rs_d    = 1'b1;
			phase_d = PH_DAT_HI;
			timer_d = load_len(cfg.data_pulse_us);
		end
	end

	// line levels after the item
	always_comb begin
		unique case (phase_d)
			PH_PWR: nib_d = 4'd0;
			PH_INIT_HI, PH_INIT_LO, PH_CMD_HI, PH_CMD_GAP, PH_DAT_HI, PH_DAT_GAP:
				nib_d = byte_d[7:4];
			default: nib_d = byte_d[3:0];
		endcase
		en_d = (phase_d == PH_INIT_HI) || (phase_d == PH_CMD_HI) ||
			(phase_d == PH_CMD_LO) || (phase_d == PH_DAT_HI) || (phase_d == PH_DAT_LO);
		busy_d = (phase_d != PH_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_PWR;
			timer_q      <= '0;
			step_q       <= 4'd0;
			byte_q       <= 8'd0;
			rs_q         <= 1'b0;
			pend_byte_q  <= 8'd0;
			pend_valid_q <= 1'b0;
			pend_cmd_q   <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (pop) begin
				phase_q      <= phase_d;
				timer_q      <= timer_d;
				step_q       <= step_d;
				byte_q       <= byte_d;
				rs_q         <= rs_d;
				pend_byte_q  <= pend_byte_d;
				pend_valid_q <= pend_valid_d;
				pend_cmd_q   <= pend_cmd_d;
				out_valid_q  <= 1'b1;
			end else if (out_ready) begin
				out_valid_q  <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			nib_q    <= nib_d;
			rs_out_q <= rs_d;
			en_q     <= en_d;
			busy_q   <= busy_d;
			rej_q    <= rej_d;
		end
	end

	assign out_valid  = out_valid_q;
	assign bus_nibble = nib_q;
	assign reg_select = rs_out_q;
	assign enable     = en_q;
	assign busy_res   = busy_q;
	assign rejected   = rej_q;

	a_en_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && en_q |-> busy_q)
		else $error("enable high on an idle result");

	a_idle_no_pend: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_IDLE) || (phase_q == PH_PWR) |-> !pend_valid_q)
		else $error("pending byte left over while idle");

	a_init_step: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_INIT_HI) || (phase_q == PH_INIT_LO) |-> step_q < 4'd4)
		else $error("init nibble phase with init step out of range");

	a_rej_busy: assert property (@(posedge clk) disable iff (!arst_n)
		pop && rej_d |-> phase_q != PH_IDLE)
		else $error("request rejected while idle");

endmodule

[sim/char_lcd_nibble_interface_unit_tb.sv]
`timescale 1ns / 1ps
// char_lcd_nibble_interface_unit_tb: self-checking bench for the 4-bit character lcd controller.
// Holds its own line-level model and compares every result transaction against it.
// Depends on lcdn_pkg and char_lcd_nibble_interface_unit.
module char_lcd_nibble_interface_unit_tb;
	import lcdn_pkg::*;

	// unused request codes, they must pass through with no effect
	localparam logic [2:0] CMD_SPARE_FIRST = 3'd5;
	localparam logic [2:0] CMD_SPARE_LAST  = 3'd7;

	localparam int unsigned INIT_NIBBLES = 4;       // init steps 0-3 are raw nibbles
	localparam int unsigned INIT_DONE    = 8;       // steps 4-7 are the setup commands
	localparam logic [7:0]  ASCII_ZERO   = 8'h30;
	localparam logic [7:0]  ASCII_BIAS   = 8'h37;   // 'A' - 10
	localparam int unsigned TAIL_CYCLES  = 8;       // drain margin after the last owed result
	localparam int unsigned CYCLE_LIMIT  = 1000000;
	localparam int unsigned HOLD_AT      = 300;     // results seen before the long stall
	localparam int unsigned HOLD_CYCLES  = 400;
	localparam int unsigned PHASE_ITEMS  = 420;

	// lines shown by one result transaction
	typedef struct packed {
		logic [3:0] nib;
		logic       rs;
		logic       en;
		logic       busy;
		logic       rej;
	} lines_t;

	// one row of the directed table
	typedef struct {
		logic [2:0] code;
		logic [7:0] val;
		logic       fin;
		bit         settle;   // tick until the bus is idle afterwards
		bit         typed;    // use the typed-in lines instead of the model
		lines_t     want;
	} dir_row_t;

	// clock and reset
	logic clk = 1'b0;
	logic arst_n = 1'b0;

	// item channel
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [2:0] cmd = CMD_TICK;
	logic [7:0] value = 8'h00;
	logic       last = 1'b0;

	// result channel
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [3:0] bus_nibble;
	logic       reg_select;
	logic       enable;
	logic       busy_res;
	logic       rejected;

	// configuration channel
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	lcdn_reg_t   cfg_index = REG_POWERUP_WAIT;
	logic [15:0] cfg_data = 16'd0;

	char_lcd_nibble_interface_unit DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.cmd        (cmd),
		.value      (value),
		.last       (last),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.bus_nibble (bus_nibble),
		.reg_select (reg_select),
		.enable     (enable),
		.busy_res   (busy_res),
		.rejected   (rejected),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// lcd line model: timing registers and bus engine state
	// ------------------------------------------------------------------
	lcdn_cfg_t   timing = '{16'd20000, 16'd5000, 16'd200, 16'd2000, 16'd2000, 16'd40};
	lcdn_phase_t lcd_phase = PH_PWR;
	int unsigned lcd_timer = 0;
	int unsigned lcd_step = 0;
	logic [7:0]  lcd_byte = 8'h00;        // byte currently on the bus
	logic        lcd_rs = 1'b0;
	logic [7:0]  queued_byte = 8'h00;     // second byte of a hex or text request
	logic        queued_valid = 1'b0;
	logic        queued_is_cmd = 1'b0;
	logic [7:0]  setup_seq [0:3] = '{BYTE_FUNCTION_SET, BYTE_DISPLAY_ON, BYTE_CLEAR,
		BYTE_ENTRY_MODE};

	// lines still owed by the block, oldest first
	lines_t lines_due [$];

	int unsigned mismatches = 0;
	int unsigned results_seen = 0;
	int unsigned cycle_count = 0;
	int unsigned burst_left = 0;
	int unsigned gap_len = 0;
	bit          steady_flow = 1'b0;  // no idling on either side

	// zero means one tick, anything beyond the timer range clamps
	function automatic int unsigned pulse_ticks(input logic [15:0] v);
		int unsigned n;
		n = (v == 16'd0) ? 1 : v;
		if (n > TIMER_MAX) n = TIMER_MAX;
		return n;
	endfunction

	function automatic logic [7:0] hex_ascii(input logic [3:0] n);
		return (n < 4'd10) ? (ASCII_ZERO | {4'd0, n}) : (ASCII_BIAS + {4'd0, n});
	endfunction

	function automatic void begin_init_nibble();
		logic [15:0] len;
		if (lcd_step == 0) len = timing.init_first_pulse_us;
		else if (lcd_step == 1) len = timing.init_second_pulse_us;
		else len = timing.init_step_pulse_us;
		// three 8-bit mode nibbles, then the switch to 4-bit
		lcd_byte = (lcd_step < 3) ? BYTE_INIT_8BIT : BYTE_INIT_4BIT;
		lcd_rs = 1'b0;
		lcd_phase = PH_INIT_HI;
		lcd_timer = pulse_ticks(len);
	endfunction

	function automatic void send_command(input logic [7:0] b);
		lcd_byte = b;
		lcd_rs = 1'b0;
		lcd_phase = PH_CMD_HI;
		lcd_timer = pulse_ticks(timing.command_pulse_us);
	endfunction

	function automatic void send_data(input logic [7:0] b);
		lcd_byte = b;
		lcd_rs = 1'b1;
		lcd_phase = PH_DAT_HI;
		lcd_timer = pulse_ticks(timing.data_pulse_us);
	endfunction

	// end of a whole byte: next setup command, queued byte, or idle
	function automatic void finish_byte();
		if (lcd_step >= INIT_NIBBLES && lcd_step < INIT_DONE) begin
			lcd_step++;
			if (lcd_step < INIT_DONE) begin
				send_command(setup_seq[lcd_step - INIT_NIBBLES]);
				return;
			end
		end
		if (queued_valid) begin
			queued_valid = 1'b0;
			if (queued_is_cmd) send_command(queued_byte);
			else send_data(queued_byte);
			return;
		end
		lcd_phase = PH_IDLE;
	endfunction

	// timer ran out: move to the next segment of the strobe sequence
	function automatic void next_segment();
		case (lcd_phase)
			PH_INIT_HI: begin
				lcd_phase = PH_INIT_LO;
				lcd_timer = 1;
			end
			PH_INIT_LO: begin
				lcd_step++;
				if (lcd_step < INIT_NIBBLES) begin_init_nibble();
				else begin
					lcd_step = INIT_NIBBLES;
					send_command(setup_seq[0]);
				end
			end
			PH_CMD_HI: begin
				lcd_phase = PH_CMD_GAP;
				lcd_timer = 1;
			end
			PH_CMD_GAP: begin
				lcd_phase = PH_CMD_LO;
				lcd_timer = pulse_ticks(timing.command_pulse_us);
			end
			PH_CMD_LO: begin
				lcd_phase = PH_CMD_WAIT;
				lcd_timer = pulse_ticks(timing.command_pulse_us);
			end
			PH_DAT_HI: begin
				lcd_phase = PH_DAT_GAP;
				lcd_timer = 1;
			end
			PH_DAT_GAP: begin
				lcd_phase = PH_DAT_LO;
				lcd_timer = pulse_ticks(timing.data_pulse_us);
			end
			PH_DAT_LO: begin
				lcd_phase = PH_DAT_END;
				lcd_timer = 1;
			end
			PH_CMD_WAIT, PH_DAT_END: finish_byte();
			default: lcd_phase = PH_IDLE;
		endcase
	endfunction

	// apply one item to the model and return the lines it leaves behind
	function automatic lines_t advance_lcd(input logic [2:0] c, input logic [7:0] v,
		input logic l);
		lines_t r;
		r = '0;
		if (c == CMD_TICK) begin
			if (lcd_phase == PH_PWR) begin
				// power-up wait counts up against a live register value
				lcd_timer = (lcd_timer + 1) & TIMER_MAX;
				if (lcd_timer >= pulse_ticks(timing.powerup_wait_us)) begin
					lcd_step = 0;
					begin_init_nibble();
				end
			end else if (lcd_phase != PH_IDLE) begin
				if (lcd_timer > 0) lcd_timer--;
				if (lcd_timer == 0) next_segment();
			end
		end else if (c <= CMD_HEX) begin
			if (lcd_phase != PH_IDLE) r.rej = 1'b1;
			else begin
				case (c)
					CMD_COMMAND: send_command(v);
					CMD_DATA: send_data(v);
					CMD_TEXT: begin
						// final character queues the trailing home command
						if (l) begin
							queued_byte = BYTE_HOME;
							queued_is_cmd = 1'b1;
							queued_valid = 1'b1;
						end
						if (v == BYTE_NEWLINE) send_command(BYTE_LINE_TWO);
						else send_data(v);
					end
					default: begin
						queued_byte = hex_ascii(v[3:0]);
						queued_is_cmd = 1'b0;
						queued_valid = 1'b1;
						send_data(hex_ascii(v[7:4]));
					end
				endcase
			end
		end
		case (lcd_phase)
			PH_PWR: r.nib = 4'h0;
			PH_INIT_HI, PH_INIT_LO, PH_CMD_HI, PH_CMD_GAP, PH_DAT_HI, PH_DAT_GAP:
				r.nib = lcd_byte[7:4];
			default: r.nib = lcd_byte[3:0];
		endcase
		r.rs = lcd_rs;
		r.en = (lcd_phase == PH_INIT_HI) || (lcd_phase == PH_CMD_HI) ||
			(lcd_phase == PH_CMD_LO) || (lcd_phase == PH_DAT_HI) || (lcd_phase == PH_DAT_LO);
		r.busy = (lcd_phase != PH_IDLE);
		return r;
	endfunction

	// ------------------------------------------------------------------
	// item side
	// ------------------------------------------------------------------

	// offer one item; bursts of random length with random gaps in between
	task automatic offer(input logic [2:0] c, input logic [7:0] v, input logic l,
		input bit typed, input lines_t want);
		lines_t got;
		if (burst_left == 0) begin
			burst_left = steady_flow ? 1000 : $urandom_range(40, 1);
			gap_len = (steady_flow || $urandom_range(3) == 0) ? 0 : $urandom_range(8, 1);
			if (gap_len != 0) begin
				in_valid <= 1'b0;
				repeat (gap_len) @(posedge clk);
			end
		end
		in_valid <= 1'b1;
		cmd <= c;
		value <= v;
		last <= l;
		do @(posedge clk); while (!in_ready);
		// transaction accepted at this edge
		got = advance_lcd(c, v, l);
		lines_due.push_back(typed ? want : got);
		burst_left--;
	endtask

	// ticks until the bus engine is back to idle
	task automatic settle_ticks();
		while (lcd_phase != PH_IDLE)
			offer(CMD_TICK, 8'($urandom_range(255)), 1'($urandom_range(1)), 1'b0, '0);
	endtask

	// stop offering and let every owed result come back
	task automatic drain_results();
		in_valid <= 1'b0;
		while (lines_due.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		burst_left = 0;
	endtask

	// leaves cfg_valid high so back-to-back writes need no toggle
	task automatic write_reg(input lcdn_reg_t idx, input logic [15:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_POWERUP_WAIT:  timing.powerup_wait_us = d;
			REG_INIT_FIRST:    timing.init_first_pulse_us = d;
			REG_INIT_SECOND:   timing.init_second_pulse_us = d;
			REG_INIT_STEP:     timing.init_step_pulse_us = d;
			REG_COMMAND_PULSE: timing.command_pulse_us = d;
			default:           timing.data_pulse_us = d;
		endcase
	endtask

	task automatic program_timing(input logic [15:0] pw, input logic [15:0] first,
		input logic [15:0] second, input logic [15:0] step, input logic [15:0] cp,
		input logic [15:0] dp);
		write_reg(REG_POWERUP_WAIT, pw);
		write_reg(REG_INIT_FIRST, first);
		write_reg(REG_INIT_SECOND, second);
		write_reg(REG_INIT_STEP, step);
		write_reg(REG_COMMAND_PULSE, cp);
		write_reg(REG_DATA_PULSE, dp);
		cfg_valid <= 1'b0;
	endtask

	// mostly well-formed requests when idle, mostly ticks while busy,
	// with rejected requests and spare codes mixed in as noise
	task automatic random_phase(input int unsigned count);
		int unsigned done_items;
		int unsigned roll;
		logic [2:0]  c;
		logic [7:0]  v;
		logic        l;
		bit          counts;
		done_items = 0;
		while (done_items < count) begin
			roll = $urandom_range(99);
			v = 8'($urandom_range(255));
			l = 1'($urandom_range(1));
			if (roll < ((lcd_phase == PH_IDLE) ? 80 : 6)) begin
				c = 3'($urandom_range(CMD_HEX, CMD_COMMAND));
				if (c == CMD_TEXT && $urandom_range(3) == 0) v = BYTE_NEWLINE;
			end else if (roll < 95) c = CMD_TICK;
			else c = 3'($urandom_range(CMD_SPARE_LAST, CMD_SPARE_FIRST));
			// spare codes and idle ticks leave the block untouched
			counts = (c <= CMD_HEX) && !(c == CMD_TICK && lcd_phase == PH_IDLE);
			offer(c, v, l, 1'b0, '0);
			if (counts) done_items++;
		end
	endtask

	// directed table; power-up wait is two ticks and every pulse one or two ticks
	dir_row_t dir_rows [0:22] = '{
		// requests and spare codes during the power-up wait
		'{CMD_COMMAND,     8'hFF, 1'b1, 1'b0, 1'b1, '{4'h0, 1'b0, 1'b0, 1'b1, 1'b1}},
		'{CMD_SPARE_LAST,  8'h00, 1'b0, 1'b0, 1'b1, '{4'h0, 1'b0, 1'b0, 1'b1, 1'b0}},
		'{CMD_TICK,        8'h00, 1'b0, 1'b0, 1'b1, '{4'h0, 1'b0, 1'b0, 1'b1, 1'b0}},
		'{CMD_HEX,         8'hA5, 1'b0, 1'b0, 1'b1, '{4'h0, 1'b0, 1'b0, 1'b1, 1'b1}},
		'{CMD_TEXT,        8'h0A, 1'b1, 1'b0, 1'b1, '{4'h0, 1'b0, 1'b0, 1'b1, 1'b1}},
		// second tick ends the wait, then run init and setup commands
		'{CMD_TICK,        8'h00, 1'b0, 1'b1, 1'b0, '0},
		// idle after setup: low nibble of the entry mode command
		'{CMD_TICK,        8'hFF, 1'b1, 1'b0, 1'b1, '{4'h6, 1'b0, 1'b0, 1'b0, 1'b0}},
		'{CMD_COMMAND,     8'h00, 1'b0, 1'b1, 1'b0, '0},
		'{CMD_COMMAND,     8'hFF, 1'b0, 1'b1, 1'b0, '0},
		'{CMD_DATA,        8'h00, 1'b0, 1'b1, 1'b0, '0},
		'{CMD_DATA,        8'hFF, 1'b1, 1'b1, 1'b0, '0},
		'{CMD_TEXT,        8'h41, 1'b0, 1'b1, 1'b0, '0},
		// newline turns into the line two command
		'{CMD_TEXT,        8'h0A, 1'b0, 1'b1, 1'b0, '0},
		'{CMD_TEXT,        8'h0A, 1'b1, 1'b1, 1'b0, '0},
		'{CMD_TEXT,        8'h5A, 1'b1, 1'b1, 1'b0, '0},
		'{CMD_HEX,         8'h00, 1'b0, 1'b1, 1'b0, '0},
		'{CMD_HEX,         8'hFF, 1'b0, 1'b1, 1'b0, '0},
		'{CMD_HEX,         8'h9A, 1'b1, 1'b1, 1'b0, '0},
		'{CMD_HEX,         8'hA9, 1'b0, 1'b1, 1'b0, '0},
		// request while a data byte is on the bus gets dropped
		'{CMD_DATA,        8'h55, 1'b0, 1'b0, 1'b0, '0},
		'{CMD_COMMAND,     8'h12, 1'b0, 1'b1, 1'b1, '{4'h5, 1'b1, 1'b1, 1'b1, 1'b1}},
		// idle tick and spare code leave the last data byte showing
		'{CMD_TICK,        8'h00, 1'b0, 1'b0, 1'b1, '{4'h5, 1'b1, 1'b0, 1'b0, 1'b0}},
		'{CMD_SPARE_FIRST, 8'hFF, 1'b1, 1'b0, 1'b1, '{4'h5, 1'b1, 1'b0, 1'b0, 1'b0}}
	};

	initial begin : stimulus
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// short power-up and init so the bring-up is quick; zero second pulse acts as one
		program_timing(16'd2, 16'd1, 16'd0, 16'd2, 16'd1, 16'd1);
		foreach (dir_rows[i]) begin
			offer(dir_rows[i].code, dir_rows[i].val, dir_rows[i].fin, dir_rows[i].typed,
				dir_rows[i].want);
			if (dir_rows[i].settle) settle_ticks();
		end

		// longer command and data pulses; init registers at their extremes
		drain_results();
		program_timing(16'd0, 16'hFFFF, 16'd1, 16'hFFFF, 16'd3, 16'd2);
		random_phase(PHASE_ITEMS);

		// every pulse register but the second init pulse at zero, which behaves as one tick
		drain_results();
		program_timing(16'hFFFF, 16'd0, 16'hFFFF, 16'd0, 16'd0, 16'd0);
		random_phase(PHASE_ITEMS);

		// long data pulse with no idling on either side; the shorter
		// value written mid-transfer only applies from the next timer load
		drain_results();
		write_reg(REG_DATA_PULSE, 16'd200);
		cfg_valid <= 1'b0;
		steady_flow = 1'b1;
		burst_left = 0;
		offer(CMD_DATA, 8'($urandom_range(255)), 1'($urandom_range(1)), 1'b0, '0);
		while (lcd_phase == PH_DAT_HI)
			offer(CMD_TICK, 8'($urandom_range(255)), 1'($urandom_range(1)), 1'b0, '0);
		drain_results();
		write_reg(REG_DATA_PULSE, 16'd1);
		cfg_valid <= 1'b0;
		settle_ticks();
		steady_flow = 1'b0;

		// random timings; second init, command and data pulses kept short
		drain_results();
		program_timing(16'($urandom), 16'($urandom), 16'($urandom_range(9, 1)), 16'($urandom),
			16'($urandom_range(5, 1)), 16'($urandom_range(5, 1)));
		random_phase(PHASE_ITEMS);

		drain_results();
		if (mismatches == 0) $display("Regression PASS");
		else $display("Regression FAIL");
		$finish;
	end

	// ------------------------------------------------------------------
	// result side
	// ------------------------------------------------------------------

	function automatic void check_line(input string name, input logic [3:0] want,
		input logic [3:0] got);
		if (got !== want) begin
			mismatches++;
			$display("%0t: %s expected %0h actual %0h", $time, name, want, got);
		end
	endfunction

	initial begin : result_side
		lines_t      want;
		lines_t      got;
		int unsigned mode;
		int unsigned mode_left;
		int unsigned hold_left;
		bit          held;
		mode = 0;
		mode_left = 0;
		hold_left = 0;
		held = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				got = {bus_nibble, reg_select, enable, busy_res, rejected};
				if (lines_due.size() == 0) begin
					mismatches++;
					$display("%0t: result with nothing outstanding: expected none actual %p",
						$time, got);
				end else begin
					want = lines_due.pop_front();
					check_line("bus_nibble", want.nib, got.nib);
					check_line("reg_select", {3'b000, want.rs}, {3'b000, got.rs});
					check_line("enable", {3'b000, want.en}, {3'b000, got.en});
					check_line("busy_res", {3'b000, want.busy}, {3'b000, got.busy});
					check_line("rejected", {3'b000, want.rej}, {3'b000, got.rej});
				end
				results_seen++;
			end
			// one long hold-off so the queue fills and in_ready drops
			if (!held && results_seen >= HOLD_AT) begin
				held = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (steady_flow) begin
				out_ready <= 1'b1;
			end else begin
				// stall pattern is redrawn when its random run ends
				if (mode_left == 0) begin
					mode = $urandom_range(3);
					mode_left = $urandom_range(80, 10);
				end
				mode_left--;
				case (mode)
					0: out_ready <= 1'b1;
					1: out_ready <= 1'($urandom_range(1));
					2: out_ready <= ($urandom_range(3) == 0);
					default: out_ready <= ~out_ready;
				endcase
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

endmodule

[filelist.f]
rtl/core/lcdn_pkg.sv
rtl/core/lcdn_front.sv
rtl/core/lcdn_queue.sv
rtl/core/lcdn_back.sv
rtl/core/char_lcd_nibble_interface_unit.sv
sim/char_lcd_nibble_interface_unit_tb.sv
